/* rtl/arp_request_responder_core_macros.svh */
// ----------------------------------------------------------------------------
// ARP responder assertion macros
// Shared concurrent assertion forms; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ARP_REQUEST_RESPONDER_CORE_MACROS_SVH
`define ARP_REQUEST_RESPONDER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARP_RR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ARP responder check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ARP_RR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ARP responder check failed in the following cycle");

`endif

/* rtl/arp_rr_pkg.sv */
// ----------------------------------------------------------------------------
// ARP responder package
// Types, frame layout offsets and codes shared by the responder modules.
// ----------------------------------------------------------------------------
package arp_rr_pkg;

    // Frame geometry: 14-byte Ethernet header followed by the 28-byte ARP body.
    localparam int FRAME_BYTES = 42;
    localparam int POS_W       = 6;
    localparam int LAST_POS    = FRAME_BYTES - 1;

    // Default depth of the reply descriptor queue.
    localparam int QUEUE_DEPTH = 2;

    // Byte offsets within the frame.
    localparam int OFF_DST_MAC = 0;
    localparam int OFF_SRC_MAC = 6;
    localparam int OFF_ETYPE   = 12;
    localparam int OFF_HW_INFO = 14;
    localparam int OFF_OPER    = 20;
    localparam int OFF_SHA     = 22;
    localparam int OFF_SPA     = 28;
    localparam int OFF_THA     = 32;
    localparam int OFF_TPA     = 38;

    localparam logic [7:0]  ETYPE_HI     = 8'h08;
    localparam logic [7:0]  ETYPE_LO     = 8'h06;
    localparam logic [15:0] OPER_REQUEST = 16'h0001;
    localparam logic [15:0] OPER_REPLY   = 16'h0002;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    typedef logic [CFG_INDEX_W-1:0] cfg_index_t;
    localparam cfg_index_t REG_OWN_IP  = 2'd0;
    localparam cfg_index_t REG_OWN_MAC = 2'd1;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_last;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       tx_last;
    } tx_item_t;

    // Everything the reply needs from the request.
    typedef struct packed {
        logic [47:0] dst_mac;     // request source MAC
        logic [47:0] hw_info;     // htype, ptype, hlen, plen
        logic [47:0] target_mac;  // request sender MAC
        logic [31:0] target_ip;   // request sender IP
    } reply_desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

/* rtl/arp_rr_rx_parser.sv */
// ----------------------------------------------------------------------------
// ARP responder receive parser
// Captures the frame header byte by byte and queues a reply descriptor for
// each ARP request addressed to the configured IP.
// ----------------------------------------------------------------------------
module arp_rr_rx_parser (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rx_valid,
    output logic                       rx_ready,
    input  arp_rr_pkg::rx_item_t       rx_item,
    input  logic [31:0]                own_ip,
    input  arp_rr_pkg::queue_status_t  status,
    output logic                       push,
    output arp_rr_pkg::reply_desc_t    desc
);
    import arp_rr_pkg::*;

    pos_t       pos_reg;
    pos_t       pos_next;
    logic       discard_reg;
    logic       discard_next;
    logic       accept;
    logic       at_last;
    logic       is_match;
    logic [7:0] hdr_reg [LAST_POS];

    // The final header byte needs room in the queue; every other byte does not.
    assign at_last  = (pos_reg == POS_W'(LAST_POS)) && !discard_reg;
    assign rx_ready = !(at_last && status.full);
    assign accept   = rx_valid && rx_ready;

    assign is_match = ({hdr_reg[OFF_OPER], hdr_reg[OFF_OPER+1]} == OPER_REQUEST) &&
                      ({hdr_reg[OFF_TPA], hdr_reg[OFF_TPA+1], hdr_reg[OFF_TPA+2],
                        rx_item.rx_byte} == own_ip);
    assign push     = accept && at_last && is_match;

    assign desc.dst_mac    = {hdr_reg[OFF_SRC_MAC],   hdr_reg[OFF_SRC_MAC+1],
                              hdr_reg[OFF_SRC_MAC+2], hdr_reg[OFF_SRC_MAC+3],
                              hdr_reg[OFF_SRC_MAC+4], hdr_reg[OFF_SRC_MAC+5]};
    assign desc.hw_info    = {hdr_reg[OFF_HW_INFO],   hdr_reg[OFF_HW_INFO+1],
                              hdr_reg[OFF_HW_INFO+2], hdr_reg[OFF_HW_INFO+3],
                              hdr_reg[OFF_HW_INFO+4], hdr_reg[OFF_HW_INFO+5]};
    assign desc.target_mac = {hdr_reg[OFF_SHA],   hdr_reg[OFF_SHA+1],
                              hdr_reg[OFF_SHA+2], hdr_reg[OFF_SHA+3],
                              hdr_reg[OFF_SHA+4], hdr_reg[OFF_SHA+5]};
    assign desc.target_ip  = {hdr_reg[OFF_SPA],   hdr_reg[OFF_SPA+1],
                              hdr_reg[OFF_SPA+2], hdr_reg[OFF_SPA+3]};

    always_comb
    begin
        pos_next     = pos_reg;
        discard_next = discard_reg;
        if (accept)
        begin
            priority if (discard_reg)
            begin
                discard_next = !rx_item.rx_last;
            end
            else if (at_last)
            begin
                pos_next     = '0;
                discard_next = !rx_item.rx_last;
            end
            else if (rx_item.rx_last)
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            discard_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            discard_reg <= discard_next;
        end
    end

    // Header bytes; the last one is compared on the fly and never stored.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LAST_POS; i++)
        begin
            if (accept && !discard_reg && (pos_reg == POS_W'(i)))
            begin
                hdr_reg[i] <= rx_item.rx_byte;
            end
        end
    end

endmodule

/* rtl/arp_rr_desc_queue.sv */
// ----------------------------------------------------------------------------
// ARP responder descriptor queue
// Small first-in first-out store of reply descriptors between the parser and
// the transmit builder. Depth must be at least two.
// ----------------------------------------------------------------------------
module arp_rr_desc_queue #(
    parameter int Depth = arp_rr_pkg::QUEUE_DEPTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  arp_rr_pkg::reply_desc_t    push_desc,
    input  logic                       pop,
    output arp_rr_pkg::reply_desc_t    head_desc,
    output arp_rr_pkg::queue_status_t  status
);
    import arp_rr_pkg::*;

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    reply_desc_t     entry_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg;
    logic [PtrW-1:0] wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg;
    logic [PtrW-1:0] rd_ptr_next;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] count_next;

    assign status.full  = (count_reg == CntW'(Depth));
    assign status.empty = (count_reg == '0);
    assign head_desc    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CntW'(1);
            2'b01:   count_next = count_reg - CntW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_desc;
        end
    end

endmodule

/* rtl/arp_rr_tx_builder.sv */
// ----------------------------------------------------------------------------
// ARP responder transmit builder
// Serialises the 42-byte reply for the descriptor at the head of the queue
// into a registered output stage.
// ----------------------------------------------------------------------------
module arp_rr_tx_builder (
    input  logic                       clk,
    input  logic                       rst_n,
    input  arp_rr_pkg::reply_desc_t    head_desc,
    input  arp_rr_pkg::queue_status_t  status,
    input  logic [31:0]                own_ip,
    input  logic [47:0]                own_mac,
    output logic                       pop,
    output logic                       tx_valid,
    input  logic                       tx_ready,
    output arp_rr_pkg::tx_item_t       tx_item
);
    import arp_rr_pkg::*;

    // Byte k of a six-byte field, most significant byte first.
    function automatic logic [7:0] mac_byte(input logic [47:0] f, input logic [2:0] k);
        logic [7:0] b;
        b = 8'h00;
        for (int i = 0; i < 6; i++)
        begin
            if (k == 3'(i))
            begin
                b = f[8*(5-i) +: 8];
            end
        end
        return b;
    endfunction

    // Byte k of a four-byte field, most significant byte first.
    function automatic logic [7:0] ip_byte(input logic [31:0] f, input logic [1:0] k);
        return f[8*(3 - int'(k)) +: 8];
    endfunction

    pos_t       idx_reg;
    pos_t       idx_next;
    logic       valid_reg;
    logic       valid_next;
    tx_item_t   item_reg;
    logic       load;
    logic       is_last;
    logic [7:0] byte_sel;

    assign load     = !status.empty && (!valid_reg || tx_ready);
    assign is_last  = (idx_reg == POS_W'(LAST_POS));
    assign pop      = load && is_last;
    assign tx_valid = valid_reg;
    assign tx_item  = item_reg;

    always_comb
    begin
        priority if (idx_reg < POS_W'(OFF_SRC_MAC))
            byte_sel = mac_byte(head_desc.dst_mac, 3'(idx_reg - POS_W'(OFF_DST_MAC)));
        else if (idx_reg < POS_W'(OFF_ETYPE))
            byte_sel = mac_byte(own_mac, 3'(idx_reg - POS_W'(OFF_SRC_MAC)));
        else if (idx_reg == POS_W'(OFF_ETYPE))
            byte_sel = ETYPE_HI;
        else if (idx_reg < POS_W'(OFF_HW_INFO))
            byte_sel = ETYPE_LO;
        else if (idx_reg < POS_W'(OFF_OPER))
            byte_sel = mac_byte(head_desc.hw_info, 3'(idx_reg - POS_W'(OFF_HW_INFO)));
        else if (idx_reg == POS_W'(OFF_OPER))
            byte_sel = OPER_REPLY[15:8];
        else if (idx_reg < POS_W'(OFF_SHA))
            byte_sel = OPER_REPLY[7:0];
        else if (idx_reg < POS_W'(OFF_SPA))
            byte_sel = mac_byte(own_mac, 3'(idx_reg - POS_W'(OFF_SHA)));
        else if (idx_reg < POS_W'(OFF_THA))
            byte_sel = ip_byte(own_ip, 2'(idx_reg - POS_W'(OFF_SPA)));
        else if (idx_reg < POS_W'(OFF_TPA))
            byte_sel = mac_byte(head_desc.target_mac, 3'(idx_reg - POS_W'(OFF_THA)));
        else
            byte_sel = ip_byte(head_desc.target_ip, 2'(idx_reg - POS_W'(OFF_TPA)));
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = is_last ? '0 : idx_reg + POS_W'(1);
            valid_next = 1'b1;
        end
        else if (tx_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.tx_byte <= byte_sel;
            item_reg.tx_last <= is_last;
        end
    end

endmodule

/* rtl/arp_request_responder_core.sv */
// ----------------------------------------------------------------------------
// ARP request responder core
// Answers Ethernet ARP requests for the configured IPv4 address with a
// 42-byte ARP reply carrying the configured MAC address.
// ----------------------------------------------------------------------------
// Usage notes.
// Frames enter one byte per transaction on the rx channel, with rx_last set
// on the final byte; one byte may be accepted in every cycle while rx_ready
// is high. The first 42 bytes are taken as the Ethernet header and ARP body;
// padding after them is dropped, as is any frame that ends before its 42nd
// byte. When the 42nd byte completes a request (operation 1) whose target IP
// equals the own IP register, a reply descriptor enters a queue of QueueDepth
// entries. The transmit builder drains it: once the descriptor has been
// written into the queue, the builder loads the first reply byte into the
// output register and offers it; the reply then goes out one byte per cycle
// while tx_ready is high, set by the single byte-wide output register.
// A stall on the tx channel holds the registered byte and pauses the builder
// only; the parser keeps accepting bytes until the queue is full and a
// further 42nd header byte arrives, which is then held off with rx_ready low
// until the builder has loaded the final byte of the oldest reply.
// Registers are written over the cfg channel, which is always ready; index 0
// is the own IP and index 1 the own MAC, other indexes are ignored. Write
// them only while the block is idle. Reset clears both registers, empties
// the queue and restarts frame parsing at the first byte.
// ----------------------------------------------------------------------------
`include "arp_request_responder_core_macros.svh"

module arp_request_responder_core #(
    parameter int QueueDepth = arp_rr_pkg::QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     rx_valid,
    output logic                     rx_ready,
    input  arp_rr_pkg::rx_item_t     rx_item,
    output logic                     tx_valid,
    input  logic                     tx_ready,
    output arp_rr_pkg::tx_item_t     tx_item,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  arp_rr_pkg::cfg_index_t   cfg_index,
    input  logic [47:0]              cfg_data
);
    import arp_rr_pkg::*;

    logic [31:0]   own_ip_reg;
    logic [31:0]   own_ip_next;
    logic [47:0]   own_mac_reg;
    logic [47:0]   own_mac_next;
    logic          push;
    logic          pop;
    reply_desc_t   push_desc;
    reply_desc_t   head_desc;
    queue_status_t status;

    // The configuration registers take a write in every cycle.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        own_ip_next  = own_ip_reg;
        own_mac_next = own_mac_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_OWN_IP:  own_ip_next  = cfg_data[31:0];
                REG_OWN_MAC: own_mac_next = cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_ip_reg  <= '0;
            own_mac_reg <= '0;
        end
        else
        begin
            own_ip_reg  <= own_ip_next;
            own_mac_reg <= own_mac_next;
        end
    end

    // Front end: header capture and request matching.
    arp_rr_rx_parser u_rx_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx_valid (rx_valid),
        .rx_ready (rx_ready),
        .rx_item  (rx_item),
        .own_ip   (own_ip_reg),
        .status   (status),
        .push     (push),
        .desc     (push_desc)
    );

    // Queue of pending replies between the two halves.
    arp_rr_desc_queue #(
        .Depth (QueueDepth)
    ) u_desc_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head_desc (head_desc),
        .status    (status)
    );

    // Back end: reply serialisation.
    arp_rr_tx_builder u_tx_builder (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_desc (head_desc),
        .status    (status),
        .own_ip    (own_ip_reg),
        .own_mac   (own_mac_reg),
        .pop       (pop),
        .tx_valid  (tx_valid),
        .tx_ready  (tx_ready),
        .tx_item   (tx_item)
    );

    // The parser must never queue a reply into a full queue.
    `ARP_RR_ASSERT_SAME(a_no_overflow, push, !status.full)
    // The builder must never release a descriptor that is not there.
    `ARP_RR_ASSERT_SAME(a_no_underflow, pop, !status.empty)
    // Input back-pressure only ever comes from a full queue.
    `ARP_RR_ASSERT_SAME(a_stall_cause, !rx_ready, status.full)
    // A reply queued into an idle back end is offered once loaded.
    `ARP_RR_ASSERT_NEXT(a_reply_starts, push && status.empty && !tx_valid, ##1 tx_valid)

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// ARP request responder testbench
// Streams Ethernet frames into the responder one byte per transaction and
// checks every reply byte against a cycle-free model of the ARP answer.
// Stimulus starts with directed requests that fill the reply queue, with a
// short and a padded frame among them, while both channels idle in random
// bursts, then random requests, wrong operations, wrong addresses, short and
// padded frames with no idling. Register writes fall between phases.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import arp_rr_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 16;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 32;

    // htype 1 (Ethernet), ptype 0x0800 (IPv4), hlen 6, plen 4.
    localparam logic [47:0] ETH_IPV4_HW_INFO = 48'h0001_0800_0604;

    // Indexes beyond the two defined registers: a write there must change nothing.
    localparam cfg_index_t REG_SPARE_LO = 2'd2;
    localparam cfg_index_t REG_SPARE_HI = 2'd3;

    typedef logic [7:0] octet_q_t[$];
    typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        rx_valid  = 1'b0;
    logic        rx_ready;
    rx_item_t    rx_item   = '0;
    logic        tx_valid;
    logic        tx_ready  = 1'b0;
    tx_item_t    tx_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    cfg_index_t  cfg_index = REG_OWN_IP;
    logic [47:0] cfg_data  = '0;

    // Mirror of the responder's frame parser and registers.
    logic [7:0]  req_hdr [FRAME_BYTES];
    pos_t        hdr_pos      = '0;
    logic        skip_padding = 1'b0;
    logic [31:0] own_ip       = '0;
    logic [47:0] own_mac      = '0;

    tx_item_t    reply_bytes_due[$];
    rx_item_t    rx_pending[$];

    int rx_sent = 0, rx_accepts = 0, tx_accepts = 0, cfg_accepts = 0;
    int mismatches = 0, frames_queued = 0, replies_predicted = 0, idle_cycles = 0;
    int rx_gap = 0, tx_stall = 0, rx_idle_pct = 0, tx_idle_pct = 0;

    arp_request_responder_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .rx_valid  (rx_valid),
        .rx_ready  (rx_ready),
        .rx_item   (rx_item),
        .tx_valid  (tx_valid),
        .tx_ready  (tx_ready),
        .tx_item   (tx_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin : clock_gen
        forever #CLK_HALF clk = ~clk;
    end

    // Takes one accepted request byte. On the 42nd header byte of a request
    // for our address the whole reply is queued as expected transactions.
    task automatic take_request_byte(input rx_item_t it);
        logic [7:0]  reply [FRAME_BYTES];
        logic [15:0] oper;
        logic [31:0] target_ip;
        if (skip_padding)
        begin
            if (it.rx_last)
                skip_padding = 1'b0;
            return;
        end
        req_hdr[hdr_pos] = it.rx_byte;
        if (hdr_pos != pos_t'(LAST_POS))
        begin
            hdr_pos = it.rx_last ? '0 : hdr_pos + 1'b1;
            return;
        end
        hdr_pos      = '0;
        skip_padding = !it.rx_last;
        oper      = {req_hdr[OFF_OPER], req_hdr[OFF_OPER + 1]};
        target_ip = {req_hdr[OFF_TPA], req_hdr[OFF_TPA + 1],
                     req_hdr[OFF_TPA + 2], req_hdr[OFF_TPA + 3]};
        if (oper != OPER_REQUEST || target_ip != own_ip)
            return;
        replies_predicted++;
        // The reply uses the same byte layout as the request.
        reply[OFF_ETYPE]    = ETYPE_HI;
        reply[OFF_ETYPE + 1] = ETYPE_LO;
        reply[OFF_OPER]     = OPER_REPLY[15:8];
        reply[OFF_OPER + 1] = OPER_REPLY[7:0];
        for (int i = 0; i < 6; i++)
        begin
            reply[OFF_DST_MAC + i] = req_hdr[OFF_SRC_MAC + i];
            reply[OFF_SRC_MAC + i] = own_mac[47 - 8 * i -: 8];
            reply[OFF_HW_INFO + i] = req_hdr[OFF_HW_INFO + i];
            reply[OFF_SHA + i]     = own_mac[47 - 8 * i -: 8];
            reply[OFF_THA + i]     = req_hdr[OFF_SHA + i];
        end
        for (int i = 0; i < 4; i++)
        begin
            reply[OFF_SPA + i] = own_ip[31 - 8 * i -: 8];
            reply[OFF_TPA + i] = req_hdr[OFF_SPA + i];
        end
        for (int i = 0; i < FRAME_BYTES; i++)
            reply_bytes_due.push_back('{tx_byte: reply[i], tx_last: (i == LAST_POS)});
    endtask

    // Builds a 42-byte ARP frame with the given operation and target IP.
    function automatic octet_q_t arp_frame(input logic [15:0] oper, input logic [31:0] tpa,
                                           input fill_t fill);
        octet_q_t f;
        for (int i = 0; i < FRAME_BYTES; i++)
        begin
            case (fill)
                FILL_ZERO: f.push_back(8'h00);
                FILL_ONES: f.push_back(8'hFF);
                default:   f.push_back(8'($urandom));
            endcase
        end
        if (fill == FILL_RANDOM)
        begin
            // The ethertype is never checked, so now and then it carries junk.
            if ($urandom_range(0, 3) != 0)
            begin
                f[OFF_ETYPE]     = ETYPE_HI;
                f[OFF_ETYPE + 1] = ETYPE_LO;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                for (int i = 0; i < 6; i++)
                    f[OFF_HW_INFO + i] = ETH_IPV4_HW_INFO[47 - 8 * i -: 8];
            end
        end
        f[OFF_OPER]     = oper[15:8];
        f[OFF_OPER + 1] = oper[7:0];
        for (int i = 0; i < 4; i++)
            f[OFF_TPA + i] = tpa[31 - 8 * i -: 8];
        return f;
    endfunction

    // Queues a frame of len bytes: the body cut short or padded with random bytes.
    task automatic queue_frame(input octet_q_t body, input int len);
        rx_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it.rx_byte = (i < body.size()) ? body[i] : 8'($urandom);
            it.rx_last = (i == len - 1);
            rx_pending.push_back(it);
        end
        frames_queued++;
    endtask

    task automatic random_traffic(input int budget);
        int          queued;
        int          pick;
        int          len;
        logic [15:0] oper;
        logic [31:0] wrong_ip;
        queued = 0;
        while (queued < budget)
        begin
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 1) == 0) ? FRAME_BYTES
                                               : FRAME_BYTES + $urandom_range(1, 24);
            if (pick < 60)
                queue_frame(arp_frame(OPER_REQUEST, own_ip, FILL_RANDOM), len);
            else if (pick < 70)
            begin
                oper = 16'($urandom);
                if (oper == OPER_REQUEST)
                    oper = OPER_REPLY;
                queue_frame(arp_frame(oper, own_ip, FILL_RANDOM), len);
            end
            else if (pick < 78)
            begin
                // A single bit of the target IP flipped.
                wrong_ip = own_ip ^ (32'h1 << $urandom_range(0, 31));
                queue_frame(arp_frame(OPER_REQUEST, wrong_ip, FILL_RANDOM), len);
            end
            else if (pick < 90)
            begin
                // A request that ends before its header is complete.
                len = $urandom_range(1, FRAME_BYTES - 1);
                queue_frame(arp_frame(OPER_REQUEST, own_ip, FILL_RANDOM), len);
            end
            else
            begin
                len = $urandom_range(1, 64);
                queue_frame(arp_frame(16'($urandom), 32'($urandom), FILL_RANDOM), len);
            end
            queued += len;
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [47:0] value);
        int seen;
        @(negedge clk);
        seen = cfg_accepts;
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        while (cfg_accepts == seen)
            @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Holds the sender until every queued byte is taken and every expected
    // reply byte has come out, then lets the block fall quiet.
    task automatic settle();
        while (rx_pending.size() != 0 || rx_accepts != rx_sent)
            @(negedge clk);
        while (reply_bytes_due.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    always @(negedge clk)
    begin : rx_driver
        // A byte on offer stays put until its transaction completes.
        if (!(rx_valid && rx_accepts != rx_sent))
        begin
            if (rx_gap > 0)
            begin
                rx_gap--;
                rx_valid <= 1'b0;
            end
            else if (rx_pending.size() != 0 && rx_idle_pct > 0
                     && $urandom_range(1, 100) <= rx_idle_pct)
            begin
                rx_gap = $urandom_range(0, 8);
                rx_valid <= 1'b0;
            end
            else if (rx_pending.size() != 0)
            begin
                rx_item  <= rx_pending.pop_front();
                rx_valid <= 1'b1;
                rx_sent++;
            end
            else
                rx_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin : tx_driver
        if (tx_stall > 0)
        begin
            tx_stall--;
            tx_ready <= 1'b0;
        end
        else if (tx_idle_pct > 0 && $urandom_range(1, 100) <= tx_idle_pct)
        begin
            tx_stall = $urandom_range(0, 8);
            tx_ready <= 1'b0;
        end
        else
            tx_ready <= 1'b1;
    end

    always @(posedge clk)
    begin : monitor
        tx_item_t due;
        if (rst_n)
        begin
            if (rx_valid && rx_ready)
            begin
                take_request_byte(rx_item);
                rx_accepts++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_OWN_IP:  own_ip  = cfg_data[31:0];
                    REG_OWN_MAC: own_mac = cfg_data;
                    default:     ;
                endcase
                cfg_accepts++;
            end
            if (tx_valid && tx_ready)
            begin
                if (reply_bytes_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected reply byte, expected none, got byte %h last %b",
                             $time, tx_item.tx_byte, tx_item.tx_last);
                end
                else
                begin
                    due = reply_bytes_due.pop_front();
                    if (tx_item.tx_byte !== due.tx_byte)
                    begin
                        mismatches++;
                        $display("%0t: reply byte %0d tx_byte expected %h, got %h", $time,
                                 tx_accepts % FRAME_BYTES, due.tx_byte, tx_item.tx_byte);
                    end
                    if (tx_item.tx_last !== due.tx_last)
                    begin
                        mismatches++;
                        $display("%0t: reply byte %0d tx_last expected %b, got %b", $time,
                                 tx_accepts % FRAME_BYTES, due.tx_last, tx_item.tx_last);
                    end
                end
                tx_accepts++;
            end
        end
        if ((rx_valid && rx_ready) || (tx_valid && tx_ready) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Both registers come out of reset as zero, so requests for 0.0.0.0
        // are answered with an all-zero MAC. The stalled receiver lets three
        // answers fill the reply queue and push back on the sender; a lone
        // short byte and a padded frame sit among them.
        rx_idle_pct = 10;
        tx_idle_pct = 60;
        queue_frame(arp_frame(OPER_REQUEST, 32'h0, FILL_ZERO), FRAME_BYTES);
        queue_frame(arp_frame(OPER_REQUEST, 32'h0, FILL_RANDOM), 1);
        queue_frame(arp_frame(OPER_REQUEST, 32'h0, FILL_ONES), FRAME_BYTES + 1);
        queue_frame(arp_frame(OPER_REQUEST, 32'h0, FILL_RANDOM), FRAME_BYTES);
        settle();

        // New settings; the IP write carries junk above bit 31, and writes
        // to the unused indexes must leave both registers alone.
        write_reg(REG_OWN_IP, {16'hFFFF, 32'($urandom)});
        write_reg(REG_OWN_MAC, {16'($urandom), 32'($urandom)});
        write_reg(REG_SPARE_LO, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SPARE_HI, {16'($urandom), 32'($urandom)});

        // The last stretch runs with no idling on either side.
        rx_idle_pct = 0;
        tx_idle_pct = 0;
        random_traffic(PHASE_BYTES);
        settle();

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d frames in %0d bytes, %0d answered; %0d reply bytes checked.",
                 frames_queued, rx_accepts, replies_predicted, tx_accepts);
        $display("Ran reset-value registers against a full reply queue, then %0d writes %s",
                 cfg_accepts, "and mixed random traffic with no idling.");
        if (mismatches == 0 && reply_bytes_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* sim.f */
+incdir+rtl
rtl/arp_rr_pkg.sv
rtl/arp_rr_rx_parser.sv
rtl/arp_rr_desc_queue.sv
rtl/arp_rr_tx_builder.sv
rtl/arp_request_responder_core.sv
tb/sv/tb.sv
